@@ rtl/wlc_pkg.sv @@
`timescale 1ns / 1ps
package wlc_pkg;

  localparam int MAX_WINDOWS  = 64;
  localparam int SLOT_W       = $clog2(MAX_WINDOWS);
  localparam int TITLE_HEIGHT = 24;
  localparam int BORDER_WIDTH = 2;

  localparam logic [31:0] COL_WEAVE_A = 32'hFF1E1E2E;
  localparam logic [31:0] COL_WEAVE_B = 32'hFF181825;
  localparam logic [31:0] COL_TITLE_F = 32'hFF313244;
  localparam logic [31:0] COL_TITLE_U = 32'hFF181825;
  localparam logic [31:0] COL_BORDER  = 32'hFF45475A;
  localparam logic [31:0] COL_CUR_IN  = 32'hFFFFFFFF;
  localparam logic [31:0] COL_CUR_OUT = 32'hFF000000;

  localparam logic [11:0] DEF_W    = 12'd400;
  localparam logic [11:0] DEF_H    = 12'd300;
  localparam logic [15:0] DEF_BASE = 16'd100;
  localparam logic [15:0] DEF_STEP = 16'd30;

  localparam int CUR_W = 12;
  localparam int CUR_H = 18;

  typedef enum logic [1:0] {
    CMD_QUERY   = 2'd0,
    CMD_CREATE  = 2'd1,
    CMD_DESTROY = 2'd2,
    CMD_MOVE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_BG     = 3'd0,
    KIND_TITLE  = 3'd1,
    KIND_BORDER = 3'd2,
    KIND_CLIENT = 3'd3,
    KIND_CURSOR = 3'd4,
    KIND_ACK    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    CFG_SCREEN_W = 2'd0,
    CFG_SCREEN_H = 2'd1,
    CFG_CURSOR_X = 2'd2,
    CFG_CURSOR_Y = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT,
    OP_LOAD,
    OP_MOVE
  } cell_op_t;

  typedef struct packed {
    logic [6:0]         id;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [11:0]        w;
    logic [11:0]        h;
  } win_rec_t;

  typedef struct packed {
    kind_t              kind;
    logic [31:0]        color;
    logic [SLOT_W-1:0]  slot;
    logic [11:0]        cx;
    logic [11:0]        cy;
    logic [11:0]        w;
  } run_t;

  function automatic logic [15:0] arrow_edge(input logic [4:0] r);
    logic [15:0] v;
    unique case (r)
      5'd0:  v = 16'h8000;
      5'd1:  v = 16'hC000;
      5'd2:  v = 16'hE000;
      5'd3:  v = 16'hF000;
      5'd4:  v = 16'hF800;
      5'd5:  v = 16'hFC00;
      5'd6:  v = 16'hFE00;
      5'd7:  v = 16'hFF00;
      5'd8:  v = 16'hFF80;
      5'd9:  v = 16'hFFC0;
      5'd10: v = 16'hFFE0;
      5'd11: v = 16'hFE00;
      5'd12: v = 16'hEE00;
      5'd13: v = 16'hCE00;
      5'd14: v = 16'h8700;
      5'd15: v = 16'h0700;
      5'd16: v = 16'h0380;
      5'd17: v = 16'h0380;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] arrow_fill(input logic [4:0] r);
    logic [15:0] v;
    unique case (r)
      5'd1:  v = 16'h4000;
      5'd2:  v = 16'h6000;
      5'd3:  v = 16'h7000;
      5'd4:  v = 16'h7800;
      5'd5:  v = 16'h7C00;
      5'd6:  v = 16'h7E00;
      5'd7:  v = 16'h7F00;
      5'd8:  v = 16'h7F80;
      5'd9:  v = 16'h7FC0;
      5'd10: v = 16'h7800;
      5'd11: v = 16'h4C00;
      5'd12: v = 16'h4C00;
      5'd13: v = 16'h0600;
      5'd14: v = 16'h0600;
      5'd15: v = 16'h0300;
      5'd16: v = 16'h0300;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/wlc_cell.sv @@
`timescale 1ns / 1ps
module wlc_cell (
  input  logic               clk,
  input  wlc_pkg::cell_op_t  op,
  input  wlc_pkg::win_rec_t  shift_in,
  input  wlc_pkg::win_rec_t  load_rec,
  output wlc_pkg::win_rec_t  rec
);
  import wlc_pkg::*;

  always_ff @(posedge clk) begin
    unique case (op)
      OP_SHIFT: rec <= shift_in;
      OP_LOAD:  rec <= load_rec;
      OP_MOVE: begin
        rec.x <= load_rec.x;
        rec.y <= load_rec.y;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/wlc_eval.sv @@
`timescale 1ns / 1ps
module wlc_eval (
  input  wlc_pkg::win_rec_t          head,
  input  logic [11:0]                px,
  input  logic [11:0]                py,
  input  logic [6:0]                 focused,
  input  logic [wlc_pkg::SLOT_W-1:0] slot,
  input  logic                       active,
  input  wlc_pkg::run_t              run_in,
  output wlc_pkg::run_t              run_out
);
  import wlc_pkg::*;

  logic signed [17:0] pxs, pys, cx, cy, dx, dy, ws, hs;
  logic in_frame, in_client;

  always_comb begin
    pxs = $signed({6'd0, px});
    pys = $signed({6'd0, py});
    ws  = $signed({6'd0, head.w});
    hs  = $signed({6'd0, head.h});
    cx  = pxs - 18'(head.x);
    cy  = pys - 18'(head.y);
    dx  = cx + 18'sd2 * 18'(BORDER_WIDTH) - 18'(BORDER_WIDTH);
    dy  = cy + 18'(TITLE_HEIGHT);
    in_frame = (dx >= 0) && (dy >= 0) && (dx < ws + 18'(2 * BORDER_WIDTH))
               && (dy < hs + 18'(TITLE_HEIGHT + BORDER_WIDTH));
    in_client = (cx >= 0) && (cx < ws) && (cy >= 0) && (cy < hs);
    run_out = run_in;
    if (active && in_frame) begin
      run_out.slot = '0;
      run_out.cx   = '0;
      run_out.cy   = '0;
      run_out.w    = '0;
      if (dy < 18'(TITLE_HEIGHT)) begin
        run_out.kind  = KIND_TITLE;
        run_out.color = (head.id == focused) ? COL_TITLE_F : COL_TITLE_U;
      end else if (in_client) begin
        run_out.kind  = KIND_CLIENT;
        run_out.color = '0;
        run_out.slot  = slot;
        run_out.cx    = cx[11:0];
        run_out.cy    = cy[11:0];
        run_out.w     = head.w;
      end else begin
        run_out.kind  = KIND_BORDER;
        run_out.color = COL_BORDER;
      end
    end
  end

endmodule

@@ rtl/window_layer_compositor.sv @@
`timescale 1ns / 1ps
// Query, destroy and move: after the item is accepted, the scan shifts the records
// once around the ring of 64 window cells, then the apply state registers the result;
// create skips the scan and goes from acceptance straight to the apply state.
// One item is in work at a time; the next item is accepted from the cycle after the
// result leaves, and the result is held until out_ready, so an output stall holds it off.
// Reset (rst, synchronous) empties the table, clears focus and restores the registers.
module window_layer_compositor (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [12:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           command,
  input  logic [11:0]          pixel_x,
  input  logic [11:0]          pixel_y,
  input  logic [6:0]           window_id,
  input  logic signed [15:0]   pos_x,
  input  logic signed [15:0]   pos_y,
  input  logic [11:0]          size_w,
  input  logic [11:0]          size_h,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           source_kind,
  output logic [31:0]          color,
  output logic [5:0]           window_slot,
  output logic [23:0]          client_offset,
  output logic [6:0]           assigned_id,
  output logic [11:0]          assigned_width,
  output logic [11:0]          assigned_height,
  output logic                 accepted
);
  import wlc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_OUT} state_t;

  state_t state;
  logic [12:0] screen_w, screen_lines;
  logic signed [12:0] cur_x, cur_y;
  logic [6:0] win_count, focused;
  logic [SLOT_W-1:0] step, fslot;
  logic found;

  cmd_t q_cmd;
  logic [11:0] q_px, q_py, q_w, q_h;
  logic [6:0] q_id;
  logic signed [15:0] q_x, q_y;
  logic q_onscreen;

  run_t run, run_next;
  win_rec_t recs [MAX_WINDOWS];
  win_rec_t load_rec;

  logic table_full;
  logic [6:0] new_id;
  logic [15:0] def_pos;
  logic [23:0] off_next;
  logic signed [13:0] cr, cc;
  logic cur_hit;
  logic [15:0] edge_row, fill_row;
  logic [3:0] bit_idx;
  logic active;

  logic [2:0]  kind_next;
  logic [31:0] color_next;
  logic [5:0]  slot_next;
  logic [23:0] offset_next;
  logic [6:0]  aid_next;
  logic [11:0] aw_next, ah_next;
  logic        acc_next;

  assign in_ready   = (state == S_IDLE);
  assign table_full = (win_count == 7'(MAX_WINDOWS));
  assign new_id     = win_count + 7'd1;
  assign def_pos    = DEF_BASE + 16'(new_id) * DEF_STEP;
  assign active     = ({1'b0, step} < win_count) && q_onscreen;

  always_comb begin
    load_rec.id = new_id;
    load_rec.x  = (q_cmd == CMD_MOVE || q_x > 0) ? q_x : $signed(def_pos);
    load_rec.y  = (q_cmd == CMD_MOVE || q_y > 0) ? q_y : $signed(def_pos);
    load_rec.w  = (q_w != 12'd0) ? q_w : DEF_W;
    load_rec.h  = (q_h != 12'd0) ? q_h : DEF_H;
  end

  for (genvar i = 0; i < MAX_WINDOWS; i++) begin : g_cell
    localparam int NXT = (i + 1) % MAX_WINDOWS;
    localparam logic [SLOT_W-1:0] IDX = SLOT_W'(i);
    cell_op_t op;

    always_comb begin
      op = OP_HOLD;
      if (state == S_SCAN) begin
        op = OP_SHIFT;
      end else if (state == S_APPLY) begin
        priority if (q_cmd == CMD_CREATE && !table_full && win_count[SLOT_W-1:0] == IDX)
          op = OP_LOAD;
        else if (q_cmd == CMD_DESTROY && found && IDX >= fslot)
          op = OP_SHIFT;
        else if (q_cmd == CMD_MOVE && found && IDX == fslot)
          op = OP_MOVE;
      end
    end

    wlc_cell u_cell (
      .clk      (clk),
      .op       (op),
      .shift_in (recs[NXT]),
      .load_rec (load_rec),
      .rec      (recs[i])
    );
  end

  wlc_eval u_eval (
    .head    (recs[0]),
    .px      (q_px),
    .py      (q_py),
    .focused (focused),
    .slot    (step),
    .active  (active),
    .run_in  (run),
    .run_out (run_next)
  );

  // Cursor sprite and client offset, resolved after the scan.
  always_comb begin
    cr       = $signed({2'b00, q_py}) - 14'(cur_y);
    cc       = $signed({2'b00, q_px}) - 14'(cur_x);
    edge_row = arrow_edge(cr[4:0]);
    fill_row = arrow_fill(cr[4:0]);
    bit_idx  = 4'd15 - cc[3:0];
    cur_hit  = q_onscreen && (cr >= 0) && (cr < 14'(CUR_H)) && (cc >= 0)
               && (cc < 14'(CUR_W)) && edge_row[bit_idx];
    off_next = run.cy * run.w + 24'(run.cx);
  end

  // Result fields of the item in the apply cycle; unused fields stay zero.
  always_comb begin
    kind_next   = KIND_ACK;
    color_next  = '0;
    slot_next   = '0;
    offset_next = '0;
    aid_next    = '0;
    aw_next     = '0;
    ah_next     = '0;
    acc_next    = 1'b0;
    unique case (q_cmd)
      CMD_QUERY: begin
        if (cur_hit) begin
          kind_next  = KIND_CURSOR;
          color_next = fill_row[bit_idx] ? COL_CUR_IN : COL_CUR_OUT;
        end else begin
          kind_next   = run.kind;
          color_next  = run.color;
          slot_next   = run.slot;
          offset_next = (run.kind == KIND_CLIENT) ? off_next : 24'd0;
        end
      end
      CMD_CREATE: begin
        if (!table_full) begin
          aid_next = new_id;
          aw_next  = load_rec.w;
          ah_next  = load_rec.h;
          acc_next = 1'b1;
        end
      end
      default: acc_next = found;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      win_count    <= '0;
      focused      <= '0;
      screen_w     <= 13'd1280;
      screen_lines <= 13'd800;
      cur_x        <= 13'sd640;
      cur_y        <= 13'sd400;
    end else begin
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_SCREEN_W: screen_w     <= cfg_data;
          CFG_SCREEN_H: screen_lines <= cfg_data;
          CFG_CURSOR_X: cur_x        <= $signed(cfg_data);
          CFG_CURSOR_Y: cur_y        <= $signed(cfg_data);
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            q_cmd      <= cmd_t'(command);
            q_px       <= pixel_x;
            q_py       <= pixel_y;
            q_id       <= window_id;
            q_x        <= pos_x;
            q_y        <= pos_y;
            q_w        <= size_w;
            q_h        <= size_h;
            q_onscreen <= ({1'b0, pixel_x} < screen_w) && ({1'b0, pixel_y} < screen_lines);
            run.kind   <= KIND_BG;
            run.color  <= (pixel_x[2] ^ pixel_y[2]) ? COL_WEAVE_A : COL_WEAVE_B;
            run.slot   <= '0;
            run.cx     <= '0;
            run.cy     <= '0;
            run.w      <= '0;
            step       <= '0;
            found      <= 1'b0;
            fslot      <= '0;
            state      <= (cmd_t'(command) == CMD_CREATE) ? S_APPLY : S_SCAN;
          end
        end
        S_SCAN: begin
          if (q_cmd == CMD_QUERY) run <= run_next;
          // remember the lowest slot holding the id
          if (!found && ({1'b0, step} < win_count) && recs[0].id == q_id) begin
            found <= 1'b1;
            fslot <= step;
          end
          step <= step + 1'b1;
          if (step == SLOT_W'(MAX_WINDOWS - 1)) state <= S_APPLY;
        end
        S_APPLY: begin
          source_kind     <= kind_next;
          color           <= color_next;
          window_slot     <= slot_next;
          client_offset   <= offset_next;
          assigned_id     <= aid_next;
          assigned_width  <= aw_next;
          assigned_height <= ah_next;
          accepted        <= acc_next;
          if (q_cmd == CMD_CREATE && !table_full) begin
            win_count <= new_id;
            focused   <= new_id;
          end else if (q_cmd == CMD_DESTROY && found) begin
            win_count <= win_count - 7'd1;
          end
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
